FILE: sv/upd_pkg.sv
// shared types, constants and digit helpers for the url percent decoder
`timescale 1ns / 1ps
package upd_pkg;

  localparam logic [7:0] CHAR_PCT   = 8'h25;
  localparam logic [7:0] CHAR_U     = 8'h75;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [5:0] DIGIT_BAD  = 6'h3F;

  localparam int QUEUE_DEPTH_DEF = 4;

  // register map
  localparam int          ADDR_W         = 3;
  localparam logic [ADDR_W-1:0] ADDR_PAIR_ORDER = 3'd0;
  localparam logic        PAIR_ORDER_RST = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_PCT  = 3'd1,
    PH_HEX2 = 3'd2,
    PH_U    = 3'd3,
    PH_U1   = 3'd4,
    PH_U2   = 3'd5,
    PH_U3   = 3'd6
  } phase_t;

  // one queue entry: one or two result beats
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic       two;
    logic       has0;
    logic       last;
  } q_entry_t;

  function automatic logic [5:0] digit_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      return d[5:0];
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      return d[5:0];
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      return d[5:0];
    end
    return DIGIT_BAD;
  endfunction

  // high digit shifted up, low digit or'd in, kept to 8 bits
  function automatic logic [7:0] make_pair(input logic [5:0] hi, input logic [5:0] lo);
    return {hi[3:0], 4'h0} | {2'b00, lo};
  endfunction

endpackage

FILE: sv/upd_front.sv
// front end: accepts encoded bytes, tracks escape phase, builds queue entries
`timescale 1ns / 1ps
module upd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // in_byte
  input  logic              s_axis_tlast,   // in_last
  input  logic              pair_order_little,
  input  logic              q_ready,
  output logic              push,
  output upd_pkg::q_entry_t entry
);
  import upd_pkg::*;

  phase_t     phase, phase_mid, phase_next;
  logic [5:0] held_digit, held_digit_next;
  logic [7:0] held_byte, held_byte_next;
  logic       accept;
  logic [5:0] v;
  logic [7:0] pair;

  assign s_axis_tready = q_ready;
  assign accept        = s_axis_tvalid && q_ready;
  assign v             = digit_value(s_axis_tdata);
  assign pair          = make_pair(held_digit, v);

  // next phase
  always_comb begin
    unique case (phase)
      PH_IDLE: phase_mid = (s_axis_tdata == CHAR_PCT) ? PH_PCT : PH_IDLE;
      PH_PCT:  phase_mid = (s_axis_tdata == CHAR_U) ? PH_U : PH_HEX2;
      PH_HEX2: phase_mid = PH_IDLE;
      PH_U:    phase_mid = PH_U1;
      PH_U1:   phase_mid = PH_U2;
      PH_U2:   phase_mid = PH_U3;
      PH_U3:   phase_mid = PH_IDLE;
      default: phase_mid = PH_IDLE;
    endcase
    if (!accept) begin
      phase_next = phase;
    end else if (s_axis_tlast) begin
      phase_next = PH_IDLE;
    end else begin
      phase_next = phase_mid;
    end
  end

  // entry and held values
  always_comb begin
    push            = 1'b0;
    entry           = '0;
    held_digit_next = held_digit;
    held_byte_next  = held_byte;
    unique case (phase)
      PH_IDLE: begin
        if (s_axis_tdata != CHAR_PCT) begin
          entry.b0   = (s_axis_tdata == CHAR_PLUS) ? CHAR_SPACE : s_axis_tdata;
          entry.has0 = 1'b1;
          push       = accept;
        end
      end
      PH_PCT: begin
        if (s_axis_tdata != CHAR_U) begin
          held_digit_next = v;
        end
      end
      PH_HEX2: begin
        entry.b0   = pair;
        entry.has0 = 1'b1;
        push       = accept;
      end
      PH_U:  held_digit_next = v;
      PH_U1: held_byte_next  = pair;
      PH_U2: held_digit_next = v;
      PH_U3: begin
        entry.two  = 1'b1;
        entry.has0 = 1'b1;
        entry.b0   = pair_order_little ? pair : held_byte;
        entry.b1   = pair_order_little ? held_byte : pair;
        push       = accept;
      end
      default: begin
      end
    endcase
    // escape cut short: end-only marker
    if (s_axis_tlast && phase_mid != PH_IDLE) begin
      entry.b0   = 8'h00;
      entry.b1   = 8'h00;
      entry.has0 = 1'b0;
      entry.two  = 1'b0;
      push       = accept;
    end
    entry.last = s_axis_tlast;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      held_digit <= '0;
      held_byte  <= '0;
    end else begin
      phase <= phase_next;
      if (accept) begin
        if (s_axis_tlast) begin
          held_digit <= '0;
          held_byte  <= '0;
        end else begin
          held_digit <= held_digit_next;
          held_byte  <= held_byte_next;
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    accept && s_axis_tlast |=> phase == PH_IDLE && held_digit == 6'h00 && held_byte == 8'h00)
    else $error("state not cleared after last byte");
  a_push_on_accept: assert property (@(posedge clk) disable iff (rst)
    push |-> accept)
    else $error("queue push without accepted byte");
`endif

endmodule

FILE: sv/upd_queue.sv
// small queue of decoded entries between front and back
`timescale 1ns / 1ps
module upd_queue #(
  parameter int DEPTH = upd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  upd_pkg::q_entry_t wr_entry,
  output logic              ready,
  input  logic              pop,
  output logic              rd_valid,
  output upd_pkg::q_entry_t rd_entry
);
  import upd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t         mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign ready    = (count != CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_entry = mem[rd_ptr];
  assign do_push  = push && ready;
  assign do_pop   = pop && rd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> ready)
    else $error("push into full queue");
`endif

endmodule

FILE: sv/upd_back.sv
// back end: turns queue entries into output beats through a registered stage
`timescale 1ns / 1ps
module upd_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  upd_pkg::q_entry_t q_entry,
  output logic              pop,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,   // out_byte
  output logic              m_axis_tuser,   // has_byte
  output logic              m_axis_tlast    // out_last
);
  import upd_pkg::*;

  logic out_valid, out_has, out_last, sel, load;
  logic [7:0] out_byte;

  assign load = !out_valid || m_axis_tready;
  assign pop  = load && q_valid && (!q_entry.two || sel);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sel       <= 1'b0;
    end else if (load) begin
      out_valid <= q_valid;
      if (q_valid && q_entry.two) begin
        sel <= !sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && q_valid) begin
      out_byte <= (q_entry.two && sel) ? q_entry.b1 : q_entry.b0;
      out_has  <= q_entry.two ? 1'b1 : q_entry.has0;
      out_last <= (q_entry.two && !sel) ? 1'b0 : q_entry.last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_byte;
  assign m_axis_tuser  = out_has;
  assign m_axis_tlast  = out_last;

`ifndef ASSERT_OFF
  a_sel_on_pair: assert property (@(posedge clk) disable iff (rst)
    sel |-> q_valid && q_entry.two)
    else $error("second byte pending without a two-byte entry");
`endif

endmodule

FILE: sv/url_percent_decoder_top.sv
// top level of the url percent decoder: config register, front, queue, back
`timescale 1ns / 1ps
// Decodes a URL-encoded byte stream, one byte per input beat. '+' becomes a
// space, "%HH" gives one byte, "%uHHHH" gives two bytes whose order follows
// the pair_order_little register (1: second pair first), other bytes pass
// through. tlast on the input ends a string; the last output beat of that
// string carries tlast. An escape cut short by tlast is dropped and a
// single end-only beat (tdata 0, tuser 0, tlast 1) is sent instead.
// Rate: one input beat per cycle, sustained. The front end decodes each byte
// as it is accepted and writes at most one entry into a queue (depth
// QUEUE_DEPTH); the back end drains one output beat per cycle while tready is
// high, a "%u" entry giving two output beats for six input bytes. An input
// beat passes the queue, then the output register. Input stalls only
// when the queue is full, i.e. when the output side holds tready low.
// Register map (APB, 32-bit data): byte address 0, bit 0 = pair_order_little,
// reset 1. Write only while the stream is idle.
module url_percent_decoder_top #(
  parameter int QUEUE_DEPTH = upd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // input stream
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,   // in_byte
  input  logic                      s_axis_tlast,   // in_last
  // output stream
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [7:0]                m_axis_tdata,   // out_byte
  output logic                      m_axis_tuser,   // has_byte
  output logic                      m_axis_tlast,   // out_last
  // config port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [upd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import upd_pkg::*;

  logic     pair_order_little;
  logic     cfg_wr;
  logic     push, q_ready, q_valid, pop;
  q_entry_t wr_entry, rd_entry;

  // config register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_order_little <= PAIR_ORDER_RST;
    end else if (cfg_wr && paddr == ADDR_PAIR_ORDER) begin
      pair_order_little <= pwdata[0];
    end
  end

  // read back, unmapped addresses read zero
  always_comb begin
    prdata = '0;
    if (paddr == ADDR_PAIR_ORDER) begin
      prdata = {31'h0, pair_order_little};
    end
  end

  // decode stage: escape tracking, one entry per completed result group
  upd_front u_front (
    .clk               (clk),
    .rst               (rst),
    .s_axis_tvalid     (s_axis_tvalid),
    .s_axis_tready     (s_axis_tready),
    .s_axis_tdata      (s_axis_tdata),
    .s_axis_tlast      (s_axis_tlast),
    .pair_order_little (pair_order_little),
    .q_ready           (q_ready),
    .push              (push),
    .entry             (wr_entry)
  );

  // decouples decode from output backpressure
  upd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .ready    (q_ready),
    .pop      (pop),
    .rd_valid (q_valid),
    .rd_entry (rd_entry)
  );

  // output stage: splits two-byte entries into beats
  upd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_entry       (rd_entry),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

`ifndef ASSERT_OFF
  a_marker_is_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && m_axis_tdata == 8'h00)
    else $error("end-only beat without last or with data");
`endif

endmodule
